// ===== rtl/spimbs_pkg.sv =====
// ----------------------------------------------------------------------------
// spimbs_pkg
// Shared types and codes of the SPI master byte shift unit.
// ----------------------------------------------------------------------------
package spimbs_pkg;

	// request operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_DIVIDER  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_POLARITY = 1'd1;

	// reset values
	localparam logic [15:0] DIVIDER_RESET = 16'd100;
	localparam logic        POLARITY_RESET = 1'b0;

	// phases within one bit
	localparam logic [1:0] PH_SET_MOSI   = 2'd0;
	localparam logic [1:0] PH_DRIVE_EDGE = 2'd1;
	localparam logic [1:0] PH_SAMPLE     = 2'd2;

	localparam logic [2:0] BIT_FIRST = 3'd7;
	localparam logic [2:0] BIT_LAST  = 3'd0;

	typedef struct packed {
		logic       sclk_level;
		logic       mosi_level;
		logic       busy_res;
		logic [7:0] rx_byte;
		logic       done_res;
	} result_t;

endpackage

// ===== rtl/spi_master_byte_shift_unit.sv =====
// ----------------------------------------------------------------------------
// spi_master_byte_shift_unit
// SPI master shifting one byte MSB first, sampling on the edge toward polarity.
// ----------------------------------------------------------------------------
//
// channel | signals                           | direction | transfer when
// --------+-----------------------------------+-----------+----------------------
// in      | in_valid in_stall + fields        | into unit | in_valid & !in_stall
// out     | out_valid out_stall + fields      | from unit | out_valid & !out_stall
// cfg     | cfg_valid cfg_ready idx data      | into unit | cfg_valid & cfg_ready
//
// every request is handled in the cycle it is accepted: the transfer state
// advances at that edge and its result lands in the output register (or the
// skid), so one request per cycle is sustained while in_stall is low.
// a skid register behind the output register lets one more request enter
// while the output is stalled; in_stall rises only when the skid is full.
// reset (arst_n low) puts the unit idle with sclk at the reset polarity,
// divider 100, and both output registers empty. configuration is always ready.

module spi_master_byte_shift_unit (
	input  logic        clk,
	input  logic        arst_n,

	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  tx_byte,
	input  logic        miso_level,

	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        sclk_level,
	output logic        mosi_level,
	output logic        busy_res,
	output logic [7:0]  rx_byte,
	output logic        done_res,

	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [spimbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                       cfg_data
);

	// configuration registers
	logic [15:0] divider_q;
	logic        polarity_q;

	// transfer state
	logic [7:0]  tx_shift_q;
	logic [7:0]  rx_shift_q;
	logic [2:0]  bit_index_q;
	logic [1:0]  phase_q;
	logic [15:0] wait_count_q;
	logic        busy_q;
	logic        sclk_q;
	logic        mosi_q;

	// next transfer state
	logic [7:0]  tx_shift_d;
	logic [7:0]  rx_shift_d;
	logic [2:0]  bit_index_d;
	logic [1:0]  phase_d;
	logic [15:0] wait_count_d;
	logic        busy_d;
	logic        sclk_d;
	logic        mosi_d;

	// output and skid registers
	spimbs_pkg::result_t out_q;
	spimbs_pkg::result_t skid_q;
	spimbs_pkg::result_t res_d;
	logic                out_vld_q;
	logic                skid_vld_q;

	logic        in_take;
	logic        out_take;
	logic        cfg_take;
	logic [15:0] span;
	logic [16:0] elapsed;
	logic [7:0]  rx_shifted;
	logic        done_d;
	logic [7:0]  rx_out_d;

	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid & cfg_ready;
	assign in_stall  = skid_vld_q;
	assign in_take   = in_valid & ~in_stall;
	assign out_take  = out_vld_q & ~out_stall;

	// divider of zero behaves as one tick per phase
	assign span       = (divider_q == 16'd0) ? 16'd1 : divider_q;
	assign elapsed    = {1'b0, wait_count_q} + 17'd1;
	assign rx_shifted = {rx_shift_q[6:0], miso_level};

	// transfer step for the request presented now
	always_comb begin
		tx_shift_d   = tx_shift_q;
		rx_shift_d   = rx_shift_q;
		bit_index_d  = bit_index_q;
		phase_d      = phase_q;
		wait_count_d = wait_count_q;
		busy_d       = busy_q;
		sclk_d       = sclk_q;
		mosi_d       = mosi_q;
		done_d       = 1'b0;
		rx_out_d     = 8'd0;
		case (operation)
			spimbs_pkg::OP_START: begin
				// start while busy is ignored
				if (!busy_q) begin
					tx_shift_d   = tx_byte;
					rx_shift_d   = 8'd0;
					bit_index_d  = spimbs_pkg::BIT_FIRST;
					phase_d      = spimbs_pkg::PH_SET_MOSI;
					wait_count_d = 16'd0;
					busy_d       = 1'b1;
					sclk_d       = ~polarity_q;
				end
			end
			spimbs_pkg::OP_TICK: begin
				if (busy_q) begin
					if (elapsed < {1'b0, span}) begin
						wait_count_d = elapsed[15:0];
					end else begin
						// phase ends on this tick
						wait_count_d = 16'd0;
						case (phase_q)
							spimbs_pkg::PH_DRIVE_EDGE: begin
								sclk_d  = polarity_q;
								phase_d = spimbs_pkg::PH_SAMPLE;
							end
							spimbs_pkg::PH_SAMPLE: begin
								rx_shift_d = rx_shifted;
								phase_d    = spimbs_pkg::PH_SET_MOSI;
								if (bit_index_q == spimbs_pkg::BIT_LAST) begin
									// last bit: go idle with sclk left at polarity
									busy_d      = 1'b0;
									done_d      = 1'b1;
									rx_out_d    = rx_shifted;
									bit_index_d = spimbs_pkg::BIT_FIRST;
								end else begin
									sclk_d      = ~polarity_q;
									bit_index_d = bit_index_q - 3'd1;
								end
							end
							default: begin
								// set-mosi phase, and the unused phase code
								mosi_d  = tx_shift_q[bit_index_q];
								phase_d = spimbs_pkg::PH_DRIVE_EDGE;
							end
						endcase
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_d.sclk_level = sclk_d;
		res_d.mosi_level = mosi_d;
		res_d.busy_res   = busy_d;
		res_d.rx_byte    = rx_out_d;
		res_d.done_res   = done_d;
	end

	// configuration and transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q    <= spimbs_pkg::DIVIDER_RESET;
			polarity_q   <= spimbs_pkg::POLARITY_RESET;
			tx_shift_q   <= 8'd0;
			rx_shift_q   <= 8'd0;
			bit_index_q  <= spimbs_pkg::BIT_FIRST;
			phase_q      <= spimbs_pkg::PH_SET_MOSI;
			wait_count_q <= 16'd0;
			busy_q       <= 1'b0;
			sclk_q       <= spimbs_pkg::POLARITY_RESET;
			mosi_q       <= 1'b0;
		end else begin
			if (in_take) begin
				tx_shift_q   <= tx_shift_d;
				rx_shift_q   <= rx_shift_d;
				bit_index_q  <= bit_index_d;
				phase_q      <= phase_d;
				wait_count_q <= wait_count_d;
				busy_q       <= busy_d;
				sclk_q       <= sclk_d;
				mosi_q       <= mosi_d;
			end
			if (cfg_take) begin
				case (cfg_index)
					spimbs_pkg::CFG_CLOCK_DIVIDER: begin
						divider_q <= cfg_data;
					end
					spimbs_pkg::CFG_CLOCK_POLARITY: begin
						polarity_q <= cfg_data[0];
						// idle sclk follows polarity at once
						if (!busy_q) begin
							sclk_q <= cfg_data[0];
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || out_take) begin
				if (skid_vld_q) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end else begin
					out_vld_q <= in_take;
				end
			end else if (in_take) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_take) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (in_take) begin
				out_q <= res_d;
			end
		end else if (in_take) begin
			skid_q <= res_d;
		end
	end

	assign out_valid  = out_vld_q;
	assign sclk_level = out_q.sclk_level;
	assign mosi_level = out_q.mosi_level;
	assign busy_res   = out_q.busy_res;
	assign rx_byte    = out_q.rx_byte;
	assign done_res   = out_q.done_res;

endmodule
